>>> sv/qpud_pkg.sv
// shared types, character codes and helper functions for the query pair decoder
package qpud_pkg;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int MAX_RES = 4;

   typedef enum logic [1:0] {
      KIND_KEY   = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_PCT  = 2'd1,
      ESC_HEX  = 2'd2
   } esc_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       done;
   } res_type;

   // results caused by one accepted byte
   typedef struct packed {
      logic [2:0]                count;
      res_type [MAX_RES-1:0]     res;
   } grp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic hex_ok(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      return v[3:0];
   endfunction

   function automatic grp_type add_res(grp_type g, kind_type k, logic [7:0] d, logic dn);
      grp_type r;
      r = g;
      if (r.count < 3'd4) begin
         r.res[r.count[1:0]] = '{kind: k, data: d, done: dn};
         r.count = r.count + 3'd1;
      end
      return r;
   endfunction

   // pending escape goes out literally
   function automatic grp_type flush_esc(grp_type g, esc_type esc, logic [7:0] held,
                                         kind_type k);
      grp_type r;
      r = g;
      if (esc != ESC_NONE) r = add_res(r, k, CHAR_PCT, 1'b0);
      if (esc == ESC_HEX) r = add_res(r, k, held, 1'b0);
      return r;
   endfunction

endpackage

>>> sv/query_pair_url_decoder.sv
// top level of the query string pair decoder
//
//  channel   ports                                   transaction when
//  -------   -------------------------------------   -------------------------
//  request   req_in_byte, req_final_req              req_push  & !req_full
//  response  rsp_kind, rsp_data, rsp_run_last,       rsp_pop   & !rsp_empty
//            rsp_query_done
//
// one byte is taken per cycle while the queue has room; the parser turns it into a
// group of zero to four results in the same cycle and writes a group with results
// into a QUEUE_DEPTH entry queue; the serializer gives one result per cycle from the
// queue head while rsp_pop is high, so the byte rate is one per cycle while bytes
// yield at most one result each; a byte with more holds the output side until all pop
// req_full is the queue full flag; rsp_empty is the queue empty flag
// synchronous reset clears the parser state, queue pointers and result index
module query_pair_url_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_req,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_run_last,
   output logic       rsp_query_done
);
   import qpud_pkg::*;

   grp_type   front_grp;
   logic      front_valid;
   grp_type   head_grp;
   qstat_type q_stat;
   logic      accept;
   logic      deq;

   // a byte is taken whenever the queue has room
   assign accept    = req_push && !q_stat.full;
   assign req_full  = q_stat.full;
   assign rsp_empty = q_stat.empty;

   // parser and pair state
   qpud_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_in_byte),
      .final_req (req_final_req),
      .accept    (accept),
      .grp       (front_grp),
      .grp_valid (front_valid)
   );

   // groups with no result never enter the queue
   qpud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_grp (front_grp),
      .pop      (deq),
      .head     (head_grp),
      .stat     (q_stat)
   );

   // result serializer
   qpud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_grp),
      .stat       (q_stat),
      .pop        (rsp_pop),
      .deq        (deq),
      .kind       (rsp_kind),
      .data       (rsp_data),
      .run_last   (rsp_run_last),
      .query_done (rsp_query_done)
   );

   // the string-closing mark is a pair end and the last result of its byte
   a_done_is_last_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_query_done) |-> (rsp_kind == KIND_END && rsp_run_last))
      else $error("query_done on a result that is not a closing pair end");

   // a pair end is always the last result of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_END) |-> rsp_run_last)
      else $error("pair end not marked as last result");

   // a full queue always has a result to give
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("queue full and empty at once");

   // a byte with results makes the response side non-empty next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      front_valid |=> !rsp_empty)
      else $error("queued group not visible");

endmodule

>>> sv/qpud_front.sv
// front end: parses one byte per cycle, when accepted, into a group of up to four results
module qpud_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        in_byte,
   input  logic              final_req,
   input  logic              accept,
   output qpud_pkg::grp_type grp,
   output logic              grp_valid
);
   import qpud_pkg::*;

   logic       value_part_ff, value_part_in;
   esc_type    esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic       seg_open_ff, seg_open_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_part_ff <= 1'b0;
         esc_ff        <= ESC_NONE;
         held_ff       <= 8'h00;
         seg_open_ff   <= 1'b0;
      end else if (accept) begin
         value_part_ff <= value_part_in;
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         seg_open_ff   <= seg_open_in;
      end
   end

   always_comb begin
      grp_type  g;
      logic     handled;
      kind_type k;
      g             = '0;
      handled       = 1'b0;
      value_part_in = value_part_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      seg_open_in   = seg_open_ff;
      k             = value_part_ff ? KIND_VALUE : KIND_KEY;

      if (in_byte == CHAR_AMP || in_byte == CHAR_SEMI) begin
         g = flush_esc(g, esc_in, held_in, k);
         if (seg_open_in) g = add_res(g, KIND_END, 8'h00, final_req);
         esc_in        = ESC_NONE;
         held_in       = 8'h00;
         value_part_in = 1'b0;
         seg_open_in   = 1'b0;
      end else begin
         seg_open_in = 1'b1;
         unique case (esc_in)
            ESC_PCT: begin
               if (hex_ok(in_byte)) begin
                  held_in = in_byte;
                  esc_in  = ESC_HEX;
                  handled = 1'b1;
               end else begin
                  g       = flush_esc(g, esc_in, held_in, k);
                  esc_in  = ESC_NONE;
                  held_in = 8'h00;
               end
            end
            ESC_HEX: begin
               if (hex_ok(in_byte)) begin
                  g       = add_res(g, k, {hex_val(held_in), hex_val(in_byte)}, 1'b0);
                  handled = 1'b1;
               end else begin
                  g = flush_esc(g, esc_in, held_in, k);
               end
               esc_in  = ESC_NONE;
               held_in = 8'h00;
            end
            default: ;
         endcase
         if (!handled) begin
            if (in_byte == CHAR_PCT) esc_in = ESC_PCT;
            else if (in_byte == CHAR_EQ && !value_part_in) value_part_in = 1'b1;
            else if (in_byte == CHAR_PLUS) g = add_res(g, k, CHAR_SPACE, 1'b0);
            else g = add_res(g, k, in_byte, 1'b0);
         end
         if (final_req) begin
            // kind may have switched on an equals sign above
            k = value_part_in ? KIND_VALUE : KIND_KEY;
            g = flush_esc(g, esc_in, held_in, k);
            g = add_res(g, KIND_END, 8'h00, 1'b1);
         end
      end

      if (final_req) begin
         value_part_in = 1'b0;
         esc_in        = ESC_NONE;
         held_in       = 8'h00;
         seg_open_in   = 1'b0;
      end

      grp       = g;
      grp_valid = accept && (g.count != 3'd0);
   end

endmodule

>>> sv/qpud_queue.sv
// short queue of result groups between the parser and the serializer
module qpud_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qpud_pkg::grp_type   push_grp,
   input  logic                pop,
   output qpud_pkg::grp_type   head,
   output qpud_pkg::qstat_type stat
);
   import qpud_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   grp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_grp;
   end

endmodule

>>> sv/qpud_back.sv
// back end: hands out the results of the head group one per pop
module qpud_back (
   input  logic                clock,
   input  logic                reset,
   input  qpud_pkg::grp_type   head,
   input  qpud_pkg::qstat_type stat,
   input  logic                pop,
   output logic                deq,
   output logic [1:0]          kind,
   output logic [7:0]          data,
   output logic                run_last,
   output logic                query_done
);
   import qpud_pkg::*;

   logic [1:0] idx_ff, idx_in;
   res_type    cur;
   logic       take;

   assign cur        = head.res[idx_ff];
   assign kind       = cur.kind;
   assign data       = cur.data;
   assign query_done = cur.done;
   assign run_last   = ({1'b0, idx_ff} == (head.count - 3'd1));
   assign take       = pop && !stat.empty;
   assign deq        = take && run_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = run_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else idx_ff <= idx_in;
   end

endmodule

>>> test/query_pair_url_decoder_tb.sv
// testbench for the query string pair decoder: directed and random byte streams
module query_pair_url_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qpud_pkg::*;

   // one decoded result as the block should present it
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       run_last;
      logic       query_done;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_final_req = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_run_last;
   logic       rsp_query_done;

   // steady mode turns off idling on both sides for the last part of the run
   logic       steady = 1'b0;
   int         pop_hold = 0;

   // predicted decoder state
   logic       pred_value_part = 1'b0;
   esc_type    pred_esc = ESC_NONE;
   logic [7:0] pred_held = 8'h00;
   logic       pred_open = 1'b0;

   decoded_type step_results[$];      // results of the byte being predicted
   decoded_type pending_results[$];   // results still owed by the block

   int         failures = 0;
   int         bytes_sent = 0;
   int         results_checked = 0;
   int         queries_closed = 0;

   query_pair_url_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_final_req  (req_final_req),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_run_last   (rsp_run_last),
      .rsp_query_done (rsp_query_done)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   function automatic logic is_hex_digit(logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] nibble_of(logic [7:0] c);
      if (c <= 8'h39) return 4'(c - 8'h30);
      if (c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
      return 4'(c - 8'h61 + 8'd10);
   endfunction

   // at most four results can come from one byte
   function automatic void put_result(kind_type k, logic [7:0] d, logic done);
      decoded_type r;
      if (step_results.size() < MAX_RES) begin
         r = '{kind: k, data: d, run_last: 1'b0, query_done: done};
         step_results.push_back(r);
      end
   endfunction

   // a byte of whichever part of the pair is being parsed
   function automatic void put_part_byte(logic [7:0] d);
      put_result(pred_value_part ? KIND_VALUE : KIND_KEY, d, 1'b0);
   endfunction

   // a pending escape goes out as literal text
   function automatic void spill_escape();
      if (pred_esc != ESC_NONE) put_part_byte(CHAR_PCT);
      if (pred_esc == ESC_HEX) put_part_byte(pred_held);
      pred_esc  = ESC_NONE;
      pred_held = 8'h00;
   endfunction

   function automatic void close_pair(logic done);
      spill_escape();
      if (pred_open) put_result(KIND_END, 8'h00, done);
      pred_value_part = 1'b0;
      pred_open       = 1'b0;
   endfunction

   // works out the results of one accepted byte and queues them
   function automatic void predict_byte(logic [7:0] b, logic last_byte);
      logic taken;
      taken = 1'b0;
      step_results.delete();
      if (b == CHAR_AMP || b == CHAR_SEMI) begin
         close_pair(last_byte);
      end else begin
         pred_open = 1'b1;
         if (pred_esc == ESC_PCT) begin
            if (is_hex_digit(b)) begin
               pred_held = b;
               pred_esc  = ESC_HEX;
               taken     = 1'b1;
            end else begin
               spill_escape();
            end
         end else if (pred_esc == ESC_HEX) begin
            if (is_hex_digit(b)) begin
               put_part_byte({nibble_of(pred_held), nibble_of(b)});
               pred_esc  = ESC_NONE;
               pred_held = 8'h00;
               taken     = 1'b1;
            end else begin
               spill_escape();
            end
         end
         // the byte that broke an escape is parsed again from scratch
         if (!taken) begin
            if (b == CHAR_PCT) pred_esc = ESC_PCT;
            else if (b == CHAR_EQ && !pred_value_part) pred_value_part = 1'b1;
            else if (b == CHAR_PLUS) put_part_byte(CHAR_SPACE);
            else put_part_byte(b);
         end
         if (last_byte) close_pair(1'b1);
      end
      if (last_byte) begin
         pred_value_part = 1'b0;
         pred_esc        = ESC_NONE;
         pred_held       = 8'h00;
         pred_open       = 1'b0;
      end
      if (step_results.size() > 0) step_results[$].run_last = 1'b1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
      failures++;
   endtask

   // a transaction on the result side is compared with the oldest prediction
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, kind", rsp_kind, 0);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_kind != want.kind) report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_data != want.data) report_mismatch("data", rsp_data, want.data);
            if (rsp_run_last != want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_query_done != want.query_done)
               report_mismatch("query_done", rsp_query_done, want.query_done);
            if (want.query_done) queries_closed++;
         end
      end
   end

   // result side stalls: bursts of random length, none in steady mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (steady) begin
         rsp_pop <= 1'b1;
      end else if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= $urandom_range(0, 10);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // holds one byte on the request side until the transaction happens,
   // then maybe idles; push stays high when the next byte follows at once
   task automatic send_byte(logic [7:0] b, logic last_byte);
      req_push      <= 1'b1;
      req_in_byte   <= b;
      req_final_req <= last_byte;
      do @(posedge clock); while (req_full);
      predict_byte(b, last_byte);
      bytes_sent++;
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // a whole query string, end marker on its last byte
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_hex_char();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(8'h30, 8'h39));
         1:       return 8'($urandom_range(8'h41, 8'h46));
         default: return 8'($urandom_range(8'h61, 8'h66));
      endcase
   endfunction

   // key, '=' with no result, bad escape with a held digit, good escape,
   // plus sign, separator, then a pair made of a lone '='
   task automatic test_pair_text();
      send_text("a=%4g%7E+;=");
   endtask

   // empty segments, escape cut short by the end of the string,
   // held digit spilled by a non-hex byte at the end (four results)
   task automatic test_escape_cases();
      send_text("&&%");
      send_text("%Ax");
   endtask

   // byte extremes, a second '=' as value text, an empty last segment
   task automatic test_separator_cases();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(CHAR_EQ, 1'b0);
      send_byte(CHAR_EQ, 1'b1);
      send_byte(CHAR_AMP, 1'b1);
   endtask

   // well-formed query strings with random content and some broken escapes
   task automatic test_random_queries(int n_bytes);
      logic [7:0] text[$];
      int         n_pairs;
      int         n_tokens;
      int         start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         text.delete();
         n_pairs = $urandom_range(1, 4);
         for (int p = 0; p < n_pairs; p++) begin
            for (int part = 0; part < 2; part++) begin
               // value side is present three times in four
               if (part == 1) begin
                  if ($urandom_range(0, 3) == 0) break;
                  text.push_back(CHAR_EQ);
               end
               n_tokens = $urandom_range(0, 4);
               for (int t = 0; t < n_tokens; t++) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2: text.push_back(8'($urandom_range(8'h61, 8'h7a)));
                     3, 4:    text.push_back(8'($urandom_range(8'h30, 8'h39)));
                     5:       text.push_back(CHAR_PLUS);
                     6, 7: begin
                        text.push_back(CHAR_PCT);
                        text.push_back(random_hex_char());
                        text.push_back(random_hex_char());
                     end
                     8:       text.push_back(CHAR_EQ);
                     default: begin
                        // escape that goes wrong on its first or second digit
                        text.push_back(CHAR_PCT);
                        if ($urandom_range(0, 1)) text.push_back(random_hex_char());
                        text.push_back(8'($urandom_range(8'h67, 8'h7a)));
                     end
                  endcase
               end
            end
            if (p < n_pairs - 1 || $urandom_range(0, 3) == 0) begin
               text.push_back($urandom_range(0, 1) ? CHAR_AMP : CHAR_SEMI);
               if ($urandom_range(0, 5) == 0) text.push_back(CHAR_SEMI);
            end
         end
         if (text.size() == 0) text.push_back(CHAR_PCT);
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      end
   endtask

   // raw noise over the whole byte range, leaning on the special characters
   task automatic test_random_bytes(int n_bytes);
      logic [7:0] b;
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       b = CHAR_AMP;
               1:       b = CHAR_SEMI;
               2:       b = CHAR_EQ;
               3:       b = CHAR_PCT;
               4:       b = CHAR_PLUS;
               default: b = random_hex_char();
            endcase
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         send_byte(b, $urandom_range(0, 11) == 0);
      end
      // leave the parser at the start of a new string
      send_byte(CHAR_SEMI, 1'b1);
   endtask

   // last stretch: both sides run without idling
   task automatic test_steady_stream(int n_bytes);
      steady <= 1'b1;
      test_random_queries(n_bytes);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_pair_text();
      test_escape_cases();
      test_separator_cases();
      test_random_queries(110);
      test_random_bytes(60);
      test_steady_stream(40);
      req_push <= 1'b0;

      // drain, then give a late extra result time to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d query bytes sent, %0d results checked, %0d query ends seen",
               bytes_sent, results_checked, queries_closed);
      $display("covered escapes good and broken, empty segments and stalls on both sides");
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard limit, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("simulation failed");
      $finish;
   end

endmodule
